>>> design/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the command frame receiver
// Holds the reset values of the registers, the sync phase encoding, the
// item command codes and the result payload type.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Register reset values
    localparam logic [7:0]  HeaderFirstReset  = 8'hCA;
    localparam logic [7:0]  HeaderSecondReset = 8'hFE;
    localparam logic [7:0]  KickCodeReset     = 8'h14;
    localparam logic [15:0] TimeoutLimitReset = 16'd500;

    // Frame geometry
    localparam int PayloadBytesDefault = 9;
    localparam int CountWidth          = 4;
    localparam int StoreDepth          = 8;
    localparam int NumSpeeds           = 4;

    // Configuration port
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_KICK_CODE     = 2'd2,
        REG_TIMEOUT_LIMIT = 2'd3
    } reg_index_t;

    // Item command codes
    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } command_t;

    // Receiver sync phase; code 3 is unused and behaves as hunting
    typedef enum logic [1:0] {
        PHASE_HUNT = 2'd0,
        PHASE_HDR1 = 2'd1,
        PHASE_DATA = 2'd2
    } phase_t;

    // One result item
    typedef struct packed {
        logic signed [15:0] speed_a;
        logic signed [15:0] speed_b;
        logic signed [15:0] speed_c;
        logic signed [15:0] speed_d;
        logic               frame_complete;
        logic               kick_request;
        logic               timed_out;
    } result_t;

endpackage

>>> design/cfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_if: channel interfaces of the command frame receiver
// cfr_item_if carries command and received byte, cfr_result_if carries the
// target speeds and frame and watchdog flags. valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfr_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_data;

    modport source (output valid, output command, output rx_data, input ready);
    modport sink   (input valid, input command, input rx_data, output ready);
endinterface

interface cfr_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic signed [15:0] speed_c;
    logic signed [15:0] speed_d;
    logic               frame_complete;
    logic               kick_request;
    logic               timed_out;

    modport source (
        output valid, output speed_a, output speed_b, output speed_c, output speed_d,
        output frame_complete, output kick_request, output timed_out, input ready
    );
    modport sink (
        input valid, input speed_a, input speed_b, input speed_c, input speed_d,
        input frame_complete, input kick_request, input timed_out, output ready
    );
endinterface

>>> design/command_frame_receiver_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver_watchdog: serial command frame receiver and watchdog
// Decodes header-framed speed commands byte by byte and zeroes the targets
// when ticks pass without a complete frame.
// ----------------------------------------------------------------------------
// Each accepted item (a received byte or a control tick) yields exactly one
// result in the following cycle, and a new item is taken every cycle: the frame
// decoder, the payload store and the watchdog all update in the cycle of the
// transfer, and the single output register takes a new item in the same cycle
// its result transfers out, so throughput is one item per clock; a stalled
// result holds off the item side until it transfers. A frame is two header
// bytes followed by PAYLOAD_BYTES payload bytes; bytes 0-7 give four signed
// big-endian speeds, latched on the last byte, which raises kick_request when
// it equals kick_code. Configuration (cfg_we/cfg_index/cfg_data) is written
// only while no item is in flight, a rule for the user, not enforced here.
// ----------------------------------------------------------------------------
module command_frame_receiver_watchdog #(
    parameter int PAYLOAD_BYTES = cfr_pkg::PayloadBytesDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cfr_item_if.sink                         item,
    cfr_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [cfr_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [cfr_pkg::CfgDataWidth-1:0]  cfg_data
);

    localparam logic [cfr_pkg::CountWidth-1:0] LastIndex =
        cfr_pkg::CountWidth'(PAYLOAD_BYTES - 1);
    localparam logic [cfr_pkg::CountWidth-1:0] StoreLimit =
        cfr_pkg::CountWidth'(cfr_pkg::StoreDepth);

    // Configuration registers
    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;
    logic [7:0]  kick_code_reg;
    logic [15:0] timeout_limit_reg;

    // Receiver and watchdog state
    cfr_pkg::phase_t                  phase_reg, phase_next;
    logic [cfr_pkg::CountWidth-1:0]   count_reg, count_next;
    logic [7:0]                       store_reg [cfr_pkg::StoreDepth];
    logic signed [15:0]               speed_reg [cfr_pkg::NumSpeeds];
    logic signed [15:0]               speed_next [cfr_pkg::NumSpeeds];
    logic [15:0]                      wd_reg, wd_next, wd_inc;

    // Output stage
    logic                             out_valid_reg;
    cfr_pkg::result_t                 out_reg, out_next;

    logic accept;
    logic is_byte;
    logic last_byte;
    logic store_we;
    logic done;
    logic kick;

    assign accept     = item.valid && item.ready;
    assign item.ready = !out_valid_reg || result.ready;
    assign is_byte    = (cfr_pkg::command_t'(item.command) == cfr_pkg::CMD_BYTE);
    assign last_byte  = (count_reg >= LastIndex);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= cfr_pkg::HeaderFirstReset;
            header_second_reg <= cfr_pkg::HeaderSecondReset;
            kick_code_reg     <= cfr_pkg::KickCodeReset;
            timeout_limit_reg <= cfr_pkg::TimeoutLimitReset;
        end
        else if (cfg_we)
        begin
            unique case (cfr_pkg::reg_index_t'(cfg_index))
                cfr_pkg::REG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                cfr_pkg::REG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                cfr_pkg::REG_KICK_CODE:     kick_code_reg     <= cfg_data[7:0];
                cfr_pkg::REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next sync phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && is_byte)
        begin
            unique case (phase_reg)
                cfr_pkg::PHASE_HDR1:
                    phase_next = (item.rx_data == header_second_reg) ?
                                 cfr_pkg::PHASE_DATA : cfr_pkg::PHASE_HUNT;
                cfr_pkg::PHASE_DATA:
                    phase_next = last_byte ? cfr_pkg::PHASE_HUNT : cfr_pkg::PHASE_DATA;
                default:
                    phase_next = (item.rx_data == header_first_reg) ?
                                 cfr_pkg::PHASE_HDR1 : cfr_pkg::PHASE_HUNT;
            endcase
        end
    end

    // Payload count, frame completion and watchdog
    always_comb
    begin
        count_next = count_reg;
        store_we   = 1'b0;
        done       = 1'b0;
        kick       = 1'b0;
        wd_inc     = (wd_reg == 16'hFFFF) ? wd_reg : wd_reg + 16'd1;
        wd_next    = wd_reg;
        for (int i = 0; i < cfr_pkg::NumSpeeds; i++)
        begin
            speed_next[i] = speed_reg[i];
        end

        if (accept)
        begin
            if (!is_byte)
            begin
                wd_next = wd_inc;
                if (wd_inc >= timeout_limit_reg)
                begin
                    for (int i = 0; i < cfr_pkg::NumSpeeds; i++)
                    begin
                        speed_next[i] = '0;
                    end
                end
            end
            else if (phase_reg == cfr_pkg::PHASE_HDR1)
            begin
                count_next = '0;
            end
            else if (phase_reg == cfr_pkg::PHASE_DATA)
            begin
                store_we = (count_reg < StoreLimit);
                if (last_byte)
                begin
                    for (int i = 0; i < cfr_pkg::NumSpeeds; i++)
                    begin
                        speed_next[i] = {store_reg[2*i], store_reg[2*i+1]};
                    end
                    kick       = (item.rx_data == kick_code_reg);
                    done       = 1'b1;
                    wd_next    = '0;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // Assemble the result of this transfer
    always_comb
    begin
        out_next.speed_a        = speed_next[0];
        out_next.speed_b        = speed_next[1];
        out_next.speed_c        = speed_next[2];
        out_next.speed_d        = speed_next[3];
        out_next.frame_complete = done;
        out_next.kick_request   = kick;
        out_next.timed_out      = (wd_next >= timeout_limit_reg);
    end

    // Advance receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfr_pkg::PHASE_HUNT;
            count_reg <= '0;
            wd_reg    <= '0;
            for (int i = 0; i < cfr_pkg::NumSpeeds; i++)
            begin
                speed_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            wd_reg    <= wd_next;
            for (int i = 0; i < cfr_pkg::NumSpeeds; i++)
            begin
                speed_reg[i] <= speed_next[i];
            end
        end
    end

    // Write payload bytes 0-7
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[$clog2(cfr_pkg::StoreDepth)-1:0]] <= item.rx_data;
        end
    end

    // Hold the result until the transfer on the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.speed_a        = out_reg.speed_a;
    assign result.speed_b        = out_reg.speed_b;
    assign result.speed_c        = out_reg.speed_c;
    assign result.speed_d        = out_reg.speed_d;
    assign result.frame_complete = out_reg.frame_complete;
    assign result.kick_request   = out_reg.kick_request;
    assign result.timed_out      = out_reg.timed_out;

endmodule

>>> design/cfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_checker: port-level checks of the command frame receiver
// Watches the item and result channels and flags flow and flag slips.
// ----------------------------------------------------------------------------
module cfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_speeds,
    input logic        out_frame,
    input logic        out_kick,
    input logic        out_timed
);

    // A kick only comes with a completed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_kick || out_frame))
        else $error("kick_request without frame_complete");

    // Every transfer in yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted item produced no result");

    // A stalled result blocks the item side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item accepted while result is stalled");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_speeds) && $stable(out_frame)
             && $stable(out_kick) && $stable(out_timed)))
        else $error("stalled result changed");

endmodule

bind command_frame_receiver_watchdog cfr_checker u_cfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_speeds ({result.speed_a, result.speed_b, result.speed_c, result.speed_d}),
    .out_frame  (result.frame_complete),
    .out_kick   (result.kick_request),
    .out_timed  (result.timed_out)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for command_frame_receiver_watchdog
// Replays a short table of directed items, then several register settings
// with random traffic: mostly well-formed frames with random payload and
// ticks mixed in, plus broken headers, tick bursts and stray bytes. Every
// result transfer is checked field by field against a directed table value
// or a bench model of decoder and watchdog. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAME_PAYLOAD = cfr_pkg::PayloadBytesDefault;
    localparam cfr_pkg::result_t IDLE_REPORT = '0;
    localparam cfr_pkg::result_t FIRST_FRAME_REPORT = '{
        speed_a: 16'sh7FFF, speed_b: 16'sh8000, speed_c: 16'shCAFE, speed_d: 16'sh0001,
        frame_complete: 1'b1, kick_request: 1'b1, timed_out: 1'b0
    };

    typedef struct packed {
        logic             fixed;
        cfr_pkg::result_t value;
    } planned_t;

    typedef struct packed {
        cfr_pkg::command_t cmd;
        logic [7:0]        data;
        logic              fixed;
        cfr_pkg::result_t  value;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [cfr_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [cfr_pkg::CfgDataWidth-1:0]  cfg_data;
    bit                                idle_on = 1'b1;
    int                                error_count = 0;
    int                                items_sent = 0;

    // Receiver model state and its copy of the registers
    cfr_pkg::phase_t rx_phase;
    logic [3:0]      rx_count;
    logic [7:0]      rx_store [cfr_pkg::StoreDepth];
    logic [15:0]     speed_q [cfr_pkg::NumSpeeds];
    logic [15:0]     wdog_q;
    logic [7:0]      hdr1_q;
    logic [7:0]      hdr2_q;
    logic [7:0]      kick_q;
    logic [15:0]     limit_q;

    planned_t         table_reports [$];
    cfr_pkg::result_t pending_reports [$];

    cfr_item_if   item_ch ();
    cfr_result_if result_ch ();

    command_frame_receiver_watchdog u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= idle_on ? ($urandom_range(99) >= 22) : 1'b1;
    end

    task automatic flag_error(string msg);
        error_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Advance the model by one item and return the report it produces
    function automatic cfr_pkg::result_t advance_receiver(cfr_pkg::command_t cmd,
                                                          logic [7:0] data);
        cfr_pkg::result_t rep;
        logic             done;
        logic             kick;
        done = 1'b0;
        kick = 1'b0;
        if (cmd == cfr_pkg::CMD_TICK)
        begin
            if (wdog_q != 16'hFFFF)
                wdog_q = wdog_q + 16'd1;
            if (wdog_q >= limit_q)
                foreach (speed_q[i]) speed_q[i] = '0;
        end
        else if (rx_phase == cfr_pkg::PHASE_HDR1)
        begin
            // a miss drops back to hunting; the byte is not looked at again
            if (data == hdr2_q)
            begin
                rx_phase = cfr_pkg::PHASE_DATA;
                rx_count = '0;
            end
            else
                rx_phase = cfr_pkg::PHASE_HUNT;
        end
        else if (rx_phase == cfr_pkg::PHASE_DATA)
        begin
            if (rx_count < cfr_pkg::StoreDepth)
                rx_store[rx_count[2:0]] = data;
            if (int'(rx_count) + 1 >= FRAME_PAYLOAD)
            begin
                // latch big-endian speeds and clear the watchdog
                for (int i = 0; i < cfr_pkg::NumSpeeds; i++)
                    speed_q[i] = {rx_store[2*i], rx_store[2*i+1]};
                kick = (data == kick_q);
                done = 1'b1;
                wdog_q = '0;
                rx_phase = cfr_pkg::PHASE_HUNT;
                rx_count = '0;
            end
            else
                rx_count = rx_count + 4'd1;
        end
        else
            rx_phase = (data == hdr1_q) ? cfr_pkg::PHASE_HDR1 : cfr_pkg::PHASE_HUNT;

        rep.speed_a = speed_q[0];
        rep.speed_b = speed_q[1];
        rep.speed_c = speed_q[2];
        rep.speed_d = speed_q[3];
        rep.frame_complete = done;
        rep.kick_request = kick;
        rep.timed_out = (wdog_q >= limit_q);
        return rep;
    endfunction

    // Track register writes, check result transfers, predict item transfers
    always @(posedge clk)
    begin
        planned_t         plan;
        cfr_pkg::result_t got;
        cfr_pkg::result_t want;
        if (!rst_n)
        begin
            rx_phase = cfr_pkg::PHASE_HUNT;
            rx_count = '0;
            foreach (rx_store[i]) rx_store[i] = '0;
            foreach (speed_q[i]) speed_q[i] = '0;
            wdog_q = '0;
            hdr1_q = cfr_pkg::HeaderFirstReset;
            hdr2_q = cfr_pkg::HeaderSecondReset;
            kick_q = cfr_pkg::KickCodeReset;
            limit_q = cfr_pkg::TimeoutLimitReset;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfr_pkg::reg_index_t'(cfg_index))
                    cfr_pkg::REG_HEADER_FIRST:  hdr1_q = cfg_data[7:0];
                    cfr_pkg::REG_HEADER_SECOND: hdr2_q = cfg_data[7:0];
                    cfr_pkg::REG_KICK_CODE:     kick_q = cfg_data[7:0];
                    cfr_pkg::REG_TIMEOUT_LIMIT: limit_q = cfg_data;
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.speed_a = result_ch.speed_a;
                got.speed_b = result_ch.speed_b;
                got.speed_c = result_ch.speed_c;
                got.speed_d = result_ch.speed_d;
                got.frame_complete = result_ch.frame_complete;
                got.kick_request = result_ch.kick_request;
                got.timed_out = result_ch.timed_out;
                if (pending_reports.size() == 0)
                    flag_error("result transfer with nothing expected");
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("speed_a", got.speed_a, want.speed_a);
                    check_field("speed_b", got.speed_b, want.speed_b);
                    check_field("speed_c", got.speed_c, want.speed_c);
                    check_field("speed_d", got.speed_d, want.speed_d);
                    check_field("frame_complete", 16'(got.frame_complete),
                                16'(want.frame_complete));
                    check_field("kick_request", 16'(got.kick_request), 16'(want.kick_request));
                    check_field("timed_out", 16'(got.timed_out), 16'(want.timed_out));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                plan = table_reports.pop_front();
                want = advance_receiver(cfr_pkg::command_t'(item_ch.command),
                                        item_ch.rx_data);
                pending_reports.push_back(plan.fixed ? plan.value : want);
            end
        end
    end

    // Drive one item and hold it until the transfer; valid stays high after
    task automatic send_item(cfr_pkg::command_t cmd, logic [7:0] data,
                             logic fixed = 1'b0, cfr_pkg::result_t value = '0);
        if (idle_on && $urandom_range(99) < 22)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        table_reports.push_back(planned_t'{fixed, value});
        item_ch.valid <= 1'b1;
        item_ch.command <= cmd;
        item_ch.rx_data <= data;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Full frame with random payload; ticks may fall anywhere inside it
    task automatic send_frame();
        logic [7:0] b;
        send_item(cfr_pkg::CMD_BYTE, hdr1_q);
        if ($urandom_range(9) == 0) send_item(cfr_pkg::CMD_TICK, 8'($urandom));
        send_item(cfr_pkg::CMD_BYTE, hdr2_q);
        for (int i = 0; i < FRAME_PAYLOAD; i++)
        begin
            if ($urandom_range(9) == 0) send_item(cfr_pkg::CMD_TICK, 8'($urandom));
            b = pick_byte();
            if (i == FRAME_PAYLOAD - 1 && $urandom_range(2) == 0)
                b = kick_q;
            send_item(cfr_pkg::CMD_BYTE, b);
        end
    endtask

    task automatic run_traffic(int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame();
            else if (pick < 80)
            begin
                // first header followed by an arbitrary byte
                send_item(cfr_pkg::CMD_BYTE, hdr1_q);
                send_item(cfr_pkg::CMD_BYTE, pick_byte());
            end
            else if (pick < 90)
                repeat ($urandom_range(1, 8)) send_item(cfr_pkg::CMD_TICK, 8'($urandom));
            else
                send_item(cfr_pkg::CMD_BYTE, pick_byte());
        end
    endtask

    // Hold off new items until every expected result is back
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfr_pkg::reg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(logic [7:0] first_byte, logic [7:0] second_byte,
                                logic [7:0] kick_byte, logic [15:0] limit);
        write_reg(cfr_pkg::REG_HEADER_FIRST, {8'h00, first_byte});
        write_reg(cfr_pkg::REG_HEADER_SECOND, {8'h00, second_byte});
        write_reg(cfr_pkg::REG_KICK_CODE, {8'h00, kick_byte});
        write_reg(cfr_pkg::REG_TIMEOUT_LIMIT, limit);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        stim_row_t directed_rows [$];
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.command <= cfr_pkg::CMD_BYTE;
        item_ch.rx_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= cfr_pkg::REG_HEADER_FIRST;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings
        directed_rows = '{
            '{cfr_pkg::CMD_TICK, 8'h00, 1'b1, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'h00, 1'b1, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderFirstReset, 1'b1, IDLE_REPORT},
            // missing second header: this first-header byte is not rechecked
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderFirstReset, 1'b1, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderSecondReset, 1'b1, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderFirstReset, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderSecondReset, 1'b0, IDLE_REPORT},
            // payload carrying speed extremes and both header values
            '{cfr_pkg::CMD_BYTE, 8'h7F, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'hFF, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'h80, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'h00, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderFirstReset, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::HeaderSecondReset, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'h00, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'h01, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, cfr_pkg::KickCodeReset, 1'b1, FIRST_FRAME_REPORT},
            '{cfr_pkg::CMD_TICK, 8'hFF, 1'b0, IDLE_REPORT},
            '{cfr_pkg::CMD_BYTE, 8'hFF, 1'b0, IDLE_REPORT}
        };
        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].data,
                      directed_rows[i].fixed, directed_rows[i].value);
        run_traffic(250);
        settle();

        // Zero limit, no idling on either side
        program_regs(cfr_pkg::HeaderFirstReset, cfr_pkg::HeaderSecondReset,
                     cfr_pkg::KickCodeReset, 16'd0);
        idle_on = 1'b0;
        run_traffic(250);
        settle();
        idle_on = 1'b1;

        program_regs(8'h00, 8'hFF, 8'hFF, 16'd1);
        run_traffic(250);
        settle();

        // Top limit
        program_regs(8'hFF, 8'h00, 8'h00, 16'hFFFF);
        run_traffic(250);
        settle();

        // Both headers and the kick code share one value
        program_regs(8'h55, 8'h55, 8'h55, 16'd2);
        run_traffic(250);
        settle();

        repeat (2)
        begin
            program_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(3, 20)));
            run_traffic(250);
            settle();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog on the run itself: far above the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
